[rtl/core/csres_pkg.sv]
// Shared types and constants of the cubic sample resampler.
package csres_pkg;

   localparam int unsigned STORE_DEPTH_DEF = 16384;

   // Widths of the configuration registers and of the payload fields.
   localparam int unsigned STEP_W   = 24;
   localparam int unsigned VOL_W    = 15;
   localparam int unsigned LEN_W    = 15;
   localparam int unsigned LOOP_W   = 8;
   localparam int unsigned CSR_W    = 24;
   localparam int unsigned CSR_IX_W = 2;
   localparam int unsigned ACC_W    = 25;
   localparam int unsigned POS_W    = 16;
   localparam int unsigned SMP_W    = 16;
   localparam int unsigned MIX_W    = 16;
   localparam int unsigned REQ_DW   = 40;

   // Datapath widths of the interpolator.
   localparam int unsigned R_W    = 21;
   localparam int unsigned MB_W   = 17;
   localparam int unsigned PROD_W = R_W + MB_W;

   localparam logic [STEP_W-1:0] STEP_RESET = 24'h010000;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_TICK  = 2'd1,
      OP_START = 2'd2
   } op_type;

   typedef enum logic [CSR_IX_W-1:0] {
      REG_PHASE_STEP    = 2'd0,
      REG_VOLUME        = 2'd1,
      REG_SAMPLE_LENGTH = 2'd2,
      REG_LOOP_COUNT    = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_FETCH,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_EMIT
   } state_type;

endpackage

[rtl/core/cubic_sample_resampler_top.sv]
// Top level of the cubic sample resampler: control sequencer, window and interpolator.
//
//   Channel  Direction  Handshake             Contents
//   req      in         req_tvalid/tready     tuser: op; tdata: address, value, mix
//   rsp      out        rsp_tvalid/tready     tdata: sample_out; tlast: channel_ended
//   csr      in         csr_we                csr_index, csr_wdata
//
// A load word writes the store, a start word makes four store reads. A tick word
// may fetch a store byte as the window moves, runs the multiplier steps unless
// idle or ending, and may wait on a full result register; the shared multiplier is
// used four times per interpolated tick. Reset is synchronous and clears the control
// state. The store is not cleared by reset. A new word is taken while a result waits.
module cubic_sample_resampler_top
   import csres_pkg::*;
#(
   parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [1:0]          req_tuser,   // op
   input  logic [REQ_DW-1:0]   req_tdata,   // load_address[13:0], load_value[21:14],
                                            // mix_in[37:22], zero fill
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [MIX_W-1:0]    rsp_tdata,   // sample_out
   output logic                rsp_tlast,   // channel_ended
   input  logic                csr_we,
   input  logic [CSR_IX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]    csr_wdata
);

   localparam int unsigned AW = $clog2(STORE_DEPTH);

   // Configuration registers.
   logic [STEP_W-1:0] phase_step_ff;
   logic [VOL_W-1:0]  volume_ff;
   logic [LEN_W-1:0]  sample_length_ff;
   logic [LOOP_W-1:0] loop_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff    <= STEP_RESET;
         volume_ff        <= '0;
         sample_length_ff <= LEN_W'(1);
         loop_count_ff    <= '0;
      end else if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_PHASE_STEP:    phase_step_ff    <= csr_wdata[STEP_W-1:0];
            REG_VOLUME:        volume_ff        <= csr_wdata[VOL_W-1:0];
            REG_SAMPLE_LENGTH: sample_length_ff <= csr_wdata[LEN_W-1:0];
            REG_LOOP_COUNT:    loop_count_ff    <= csr_wdata[LOOP_W-1:0];
            default: ;
         endcase
      end
   end

   // Request fields.
   op_type          req_op;
   logic [13:0]     req_addr;
   logic [7:0]      req_value;
   logic [MIX_W-1:0] req_mix;
   assign req_op    = op_type'(req_tuser);
   assign req_addr  = req_tdata[13:0];
   assign req_value = req_tdata[21:14];
   assign req_mix   = req_tdata[37:22];

   // State.
   state_type               state_ff, state_in;
   logic                    playing_ff, playing_in;
   logic [LOOP_W-1:0]       loops_left_ff, loops_left_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic signed [SMP_W-1:0] win_ff [4];
   logic signed [SMP_W-1:0] win_in [4];
   logic [2:0]              cnt_ff, cnt_in;
   logic [15:0]             frac_ff, frac_in;
   logic [MIX_W-1:0]        mix_ff, mix_in;
   logic signed [R_W-1:0]   r_ff, r_in;
   logic [MIX_W-1:0]        res_ff, res_in;
   logic                    res_end_ff, res_end_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [MIX_W-1:0]        rsp_tdata_ff, rsp_tdata_in;
   logic                    rsp_tlast_ff, rsp_tlast_in;

   // Store.
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [7:0]    ram_rdata;

   csres_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_value),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   logic signed [SMP_W-1:0] fetched;
   assign fetched = $signed({ram_rdata, 8'h00});

   // Interpolation coefficients from the window.
   logic signed [R_W-1:0] a0, a1, a2, x1;
   assign x1 = R_W'(win_ff[1]);
   assign a0 = R_W'(win_ff[3]) - R_W'(win_ff[2]) - R_W'(win_ff[0]) + x1;
   assign a1 = R_W'(win_ff[0]) - x1 - a0;
   assign a2 = R_W'(win_ff[2]) - R_W'(win_ff[0]);

   // Shared multiplier.
   logic signed [R_W-1:0]    mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] prod_fl;
   logic signed [PROD_W-1:0] prod_rnd;
   logic signed [MIX_W-1:0]  term;
   assign prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign prod_fl  = prod >>> 16;
   assign prod_rnd = prod + (prod[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
   assign term     = MIX_W'(prod_rnd >>> 8);

   logic                 wrap;
   logic [8:0]           carry;
   logic [POS_W-1:0]     new_pos;
   logic [31:0]          addr_tmp;
   logic                 out_free;
   logic                 accept;

   assign wrap     = loops_left_ff > LOOP_W'(1);
   assign carry    = acc_ff[ACC_W-1:16];
   assign new_pos  = pos_ff + POS_W'(carry);
   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign accept   = req_tvalid && req_tready;

   always_comb begin
      state_in      = state_ff;
      playing_in    = playing_ff;
      loops_left_in = loops_left_ff;
      pos_in        = pos_ff;
      acc_in        = acc_ff;
      win_in        = win_ff;
      cnt_in        = cnt_ff;
      frac_in       = frac_ff;
      mix_in        = mix_ff;
      r_in          = r_ff;
      res_in        = res_ff;
      res_end_in    = res_end_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      req_tready    = state_ff == ST_IDLE;
      ram_we        = 1'b0;
      ram_waddr     = AW'(32'(req_addr));
      ram_raddr     = '0;
      addr_tmp      = '0;
      mul_a         = r_ff;
      mul_b         = MB_W'(frac_ff);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mix_in = req_mix;
               case (req_op)
                  OP_LOAD: ram_we = 1'b1;
                  OP_START: begin
                     playing_in    = 1'b1;
                     loops_left_in = loop_count_ff;
                     pos_in        = '0;
                     acc_in        = '0;
                     addr_tmp      = 32'(sample_length_ff) + 32'(STORE_DEPTH) - 32'd1;
                     ram_raddr     = addr_tmp[AW-1:0];
                     cnt_in        = 3'd1;
                     state_in      = ST_START;
                  end
                  OP_TICK: begin
                     res_in     = req_mix;
                     res_end_in = 1'b0;
                     state_in   = ST_EMIT;
                     if (playing_ff) begin
                        frac_in  = acc_ff[15:0];
                        state_in = ST_MUL0;
                        if (carry != 9'd0) begin
                           pos_in    = new_pos;
                           win_in[0] = win_ff[1];
                           win_in[1] = win_ff[2];
                           win_in[2] = win_ff[3];
                           win_in[3] = '0;
                           if ($signed({2'b00, new_pos}) <
                               $signed({3'b000, sample_length_ff}) - 18'sd3) begin
                              addr_tmp  = 32'(new_pos) + 32'd2;
                              ram_raddr = addr_tmp[AW-1:0];
                              state_in  = ST_FETCH;
                           end else if ({1'b0, new_pos} >=
                                        17'(sample_length_ff) + 17'd1) begin
                              if (wrap) begin
                                 loops_left_in = loops_left_ff - LOOP_W'(1);
                                 pos_in        = '0;
                                 frac_in       = '0;
                              end else begin
                                 playing_in = 1'b0;
                                 res_end_in = 1'b1;
                                 state_in   = ST_EMIT;
                              end
                           end
                        end
                        // The accumulator keeps its fraction, or none after a restart.
                        if (state_in != ST_EMIT) begin
                           acc_in = ACC_W'(frac_in) + ACC_W'(phase_step_ff);
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_START: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff != 3'd4) begin
               ram_raddr = AW'(32'(cnt_ff - 3'd1));
            end
            case (cnt_ff)
               3'd1: win_in[0] = wrap ? fetched : '0;
               3'd2: begin
                  win_in[1] = fetched;
                  win_in[2] = wrap ? fetched : '0;
                  win_in[3] = wrap ? fetched : '0;
               end
               3'd3: if (sample_length_ff > LEN_W'(1)) win_in[2] = fetched;
               default: begin
                  if (sample_length_ff > LEN_W'(2)) win_in[3] = fetched;
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_FETCH: begin
            win_in[3] = fetched;
            state_in  = ST_MUL0;
         end
         ST_MUL0: begin
            mul_a    = a0;
            r_in     = R_W'(prod_fl) + a1;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            r_in     = R_W'(prod_fl) + a2;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            r_in     = R_W'(prod_fl) + x1;
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            mul_b    = MB_W'(volume_ff[VOL_W-1:1]);
            res_in   = mix_ff + MIX_W'(term);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = res_ff;
               rsp_tlast_in  = res_end_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         playing_ff    <= 1'b0;
         loops_left_ff <= '0;
         pos_ff        <= '0;
         acc_ff        <= '0;
         win_ff        <= '{default: '0};
         cnt_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         playing_ff    <= playing_in;
         loops_left_ff <= loops_left_in;
         pos_ff        <= pos_in;
         acc_ff        <= acc_in;
         win_ff        <= win_in;
         cnt_ff        <= cnt_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      frac_ff      <= frac_in;
      mix_ff       <= mix_in;
      r_ff         <= r_in;
      res_ff       <= res_in;
      res_end_ff   <= res_end_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // A store fetch only follows a tick word taken in the previous cycle.
   a_fetch_after_tick: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FETCH |-> $past(accept) && $past(req_op == OP_TICK))
      else $error("store fetch without a tick word");

   // The loop count only steps down by one, outside a start.
   a_loop_step: assert property (@(posedge clock) disable iff (reset)
      $past(state_ff == ST_IDLE) && !($past(accept) && $past(req_op == OP_START)) &&
      loops_left_ff != $past(loops_left_ff)
      |-> loops_left_ff == $past(loops_left_ff) - LOOP_W'(1))
      else $error("loop count changed unexpectedly");

   // The multiplier steps run in a fixed order and end in the result stage.
   a_mul_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL3 |=> state_ff == ST_EMIT)
      else $error("interpolator sequence broken");

endmodule

[rtl/core/csres_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module csres_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[bench/tb_top.sv]
// Self-checking bench for the cubic sample resampler: directed words, then random phases.
module tb_top;
   import csres_pkg::*;

   localparam int unsigned DEPTH = STORE_DEPTH_DEF;
   // The op code that the block must ignore.
   localparam logic [1:0] OP_NONE = 2'd3;
   localparam int unsigned WORDS_PER_PHASE = 240;

   // Scoreboard: a bit-true copy of the channel and the queue of expected samples.
   class resampler_scoreboard;
      logic [7:0]  store_bytes [DEPTH];
      bit          store_written [DEPTH];
      bit [15:0]   position;
      bit [24:0]   phase_acc;
      int          window [4];
      bit [7:0]    loops_remaining;
      bit          active;
      bit [23:0]   step_reg;
      bit [14:0]   volume_reg;
      bit [14:0]   length_reg;
      bit [7:0]    loop_reg;
      bit [16:0]   expected_samples [$];
      int          errors, ticks, endings, restarts, loads, starts;

      function new();
         position = 0;
         phase_acc = 0;
         foreach (window[i]) window[i] = 0;
         loops_remaining = 0;
         active = 0;
         step_reg = STEP_RESET;
         volume_reg = 0;
         length_reg = 1;
         loop_reg = 0;
      endfunction

      task report(string what);
         errors++;
         $display("MISMATCH at %0t: %s", $realtime, what);
      endtask

      function void write_reg(reg_index_type ix, bit [23:0] value);
         case (ix)
            REG_PHASE_STEP:    step_reg = value;
            REG_VOLUME:        volume_reg = value[14:0];
            REG_SAMPLE_LENGTH: length_reg = value[14:0];
            REG_LOOP_COUNT:    loop_reg = value[7:0];
            default: ;
         endcase
      endfunction

      function int scaled_byte(int unsigned idx);
         return int'($signed(store_bytes[idx % DEPTH])) * 256;
      endfunction

      // Index of a store entry that the next word of this op would read unwritten, or -1.
      function int unwritten_read(logic [1:0] op);
         int unsigned cand [$];
         bit [15:0] np;
         if (op == OP_START) begin
            if (loop_reg > 1) cand.push_back((length_reg + DEPTH - 1) % DEPTH);
            cand.push_back(0);
            if (length_reg > 1) cand.push_back(1);
            if (length_reg > 2) cand.push_back(2);
         end else if (op == OP_TICK && active && phase_acc[24:16] != 0) begin
            np = position + phase_acc[24:16];
            if (int'(np) < int'(length_reg) - 3) cand.push_back((np + 2) % DEPTH);
         end
         foreach (cand[i]) if (!store_written[cand[i]]) return cand[i];
         return -1;
      endfunction

      function void note_word(logic [1:0] op, bit [13:0] addr, bit [7:0] value, bit [15:0] mix);
         bit wrap;
         bit [8:0] carry;
         bit restarted;
         longint x0, x1, x2, x3, a0, a1, a2, f, r, term;
         case (op)
            OP_LOAD: begin
               store_bytes[addr % DEPTH] = value;
               store_written[addr % DEPTH] = 1;
               loads++;
            end
            OP_START: begin
               wrap = loop_reg > 1;
               active = 1;
               loops_remaining = loop_reg;
               position = 0;
               phase_acc = 0;
               window[0] = wrap ? scaled_byte(length_reg + DEPTH - 1) : 0;
               window[1] = scaled_byte(0);
               window[2] = length_reg > 1 ? scaled_byte(1) : (wrap ? scaled_byte(0) : 0);
               window[3] = length_reg > 2 ? scaled_byte(2) : (wrap ? scaled_byte(0) : 0);
               starts++;
            end
            OP_TICK: begin
               ticks++;
               if (!active) begin
                  expected_samples.push_back({1'b0, mix});
                  return;
               end
               carry = phase_acc[24:16];
               restarted = 0;
               if (carry != 0) begin
                  position = position + carry;
                  window[0] = window[1];
                  window[1] = window[2];
                  window[2] = window[3];
                  if (int'(position) < int'(length_reg) - 3) begin
                     window[3] = scaled_byte(position + 2);
                  end else begin
                     window[3] = 0;
                     if (int'(position) >= int'(length_reg) + 1) begin
                        if (loops_remaining > 1) begin
                           loops_remaining--;
                           position = 0;
                           phase_acc = 0;
                           restarted = 1;
                           restarts++;
                        end else begin
                           active = 0;
                           endings++;
                           expected_samples.push_back({1'b1, mix});
                           return;
                        end
                     end
                  end
               end
               x0 = window[0];
               x1 = window[1];
               x2 = window[2];
               x3 = window[3];
               a0 = x3 - x2 - x0 + x1;
               a1 = x0 - x1 - a0;
               a2 = x2 - x0;
               f = restarted ? 0 : longint'(phase_acc[15:0]);
               // Arithmetic shifts give the rounding toward minus infinity.
               r = ((a0 * f) >>> 16) + a1;
               r = ((r * f) >>> 16) + a2;
               r = ((r * f) >>> 16) + x1;
               term = (r * longint'(volume_reg >> 1)) / 256;
               expected_samples.push_back({1'b0, 16'(longint'(mix) + term)});
               phase_acc = 25'({9'd0, phase_acc[15:0]} + step_reg);
            end
            default: ;
         endcase
      endfunction

      task check_word(bit [15:0] sample, bit ended);
         bit [16:0] want;
         if (expected_samples.size() == 0) begin
            report($sformatf("unexpected word %h/%b", sample, ended));
            return;
         end
         want = expected_samples.pop_front();
         if (sample !== want[15:0])
            report($sformatf("sample_out %h, expected %h", sample, want[15:0]));
         if (ended !== want[16])
            report($sformatf("channel_ended %b, expected %b", ended, want[16]));
      endtask
   endclass

   logic                clock = 0;
   logic                reset = 1;
   logic                req_tvalid = 0;
   logic                req_tready;
   logic [1:0]          req_tuser = OP_LOAD;
   logic [REQ_DW-1:0]   req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 0;
   logic [MIX_W-1:0]    rsp_tdata;
   logic                rsp_tlast;
   logic                csr_we = 0;
   logic [CSR_IX_W-1:0] csr_index = REG_PHASE_STEP;
   logic [CSR_W-1:0]    csr_wdata = '0;

   resampler_scoreboard sb = new();
   bit send_gaps, rx_stalls;

   cubic_sample_resampler_top dut (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata, rsp_tlast);
      rsp_tready <= reset ? 1'b0 : (rx_stalls ? ($urandom_range(99) >= 80) : 1'b1);
   end

   task put_word(logic [1:0] op, bit [13:0] addr, bit [7:0] value, bit [15:0] mix);
      req_tvalid <= 1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, mix, value, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_word(op, addr, value, mix);
      if (send_gaps && $urandom_range(99) < 80) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // Loads any byte that the coming word would otherwise read unwritten, then sends it.
   task send_op(logic [1:0] op, bit [15:0] mix);
      int idx;
      idx = sb.unwritten_read(op);
      while (idx >= 0) begin
         put_word(OP_LOAD, 14'(idx), 8'($urandom), 16'($urandom));
         idx = sb.unwritten_read(op);
      end
      put_word(op, 14'($urandom), 8'($urandom), mix);
   endtask

   task drain;
      req_tvalid <= 0;
      @(posedge clock);
      while (sb.expected_samples.size() != 0) @(posedge clock);
      // Loads and starts give no word back, so allow the longest of them to finish.
      repeat (12) @(posedge clock);
   endtask

   task write_reg(reg_index_type ix, bit [23:0] value);
      csr_we    <= 1;
      csr_index <= ix;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(ix, value);
   endtask

   task configure(bit [23:0] step, bit [14:0] vol, bit [14:0] len, bit [7:0] loops);
      write_reg(REG_PHASE_STEP, step);
      write_reg(REG_VOLUME, vol);
      write_reg(REG_SAMPLE_LENGTH, len);
      write_reg(REG_LOOP_COUNT, loops);
      csr_we <= 0;
      @(posedge clock);
   endtask

   initial begin
      int pick;
      bit [23:0] step;
      bit [14:0] len;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: idle tick, extreme bytes, the ignored op, a loop restart and an ending.
      send_op(OP_TICK, 16'hFFFF);
      put_word(OP_LOAD, 0, 8'h7F, 0);
      put_word(OP_LOAD, 1, 8'h80, 0);
      put_word(OP_LOAD, 2, 8'h00, 0);
      put_word(OP_LOAD, 14'h3FFF, 8'hFF, 0);
      put_word(OP_NONE, 14'h3FFF, 8'hFF, 16'hFFFF);
      send_op(OP_START, 0);
      repeat (3) send_op(OP_TICK, 16'h0000);
      drain();
      configure(24'h00C000, 15'h7FFF, 3, 2);
      send_op(OP_START, 0);
      repeat (10) send_op(OP_TICK, 16'($urandom));
      drain();
      configure(24'hFFFFFF, 15'h7FFF, 15'd16384, 1);
      send_op(OP_START, 0);
      repeat (3) send_op(OP_TICK, 16'hFFFF);

      for (int ph = 0; ph < 8; ph++) begin
         drain();
         send_gaps = (ph % 4 == 1) || (ph % 4 == 3);
         rx_stalls = (ph % 4 == 2) || (ph % 4 == 3);
         step = (ph == 3) ? 24'd0 : (ph == 6) ? 24'hFFFFFF : 24'($urandom_range(24'h2000, 24'h38000));
         len  = (ph == 2) ? 15'd1 : (ph == 5) ? 15'd16384 : 15'($urandom_range(2, 48));
         configure(step, (ph == 4) ? 15'd0 : 15'($urandom_range(0, 32767)), len,
                   (ph == 1) ? 8'd255 : (ph == 7) ? 8'd0 : 8'($urandom_range(0, 4)));
         send_op(OP_START, 0);
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            pick = $urandom_range(99);
            if (pick < 6)
               put_word(OP_LOAD, 14'($urandom), 8'($urandom), 16'($urandom));
            else if (pick < 7)
               put_word(OP_NONE, 14'($urandom), 8'($urandom), 16'($urandom));
            else if (pick < 11 || (!sb.active && pick < 40))
               send_op(OP_START, 16'($urandom));
            else
               send_op(OP_TICK, 16'($urandom));
         end
      end

      drain();
      repeat (20) @(posedge clock);
      $display("Covered %0d ticks, %0d starts, %0d loads, %0d loop restarts, %0d endings.",
               sb.ticks, sb.starts, sb.loads, sb.restarts, sb.endings);
      if (sb.errors == 0 && sb.expected_samples.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("%0d mismatches, %0d words outstanding.", sb.errors,
                  sb.expected_samples.size());
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #(12 * 600000);
      $display("Timed out.");
      $display("DONE: errors detected");
      $finish;
   end

endmodule
